@@ rtl/pybs_pkg.sv @@
// ----------------------------------------------------------------------------
// pybs_pkg
// Shared types, format codes and lookup functions for the packed pixel
// stream to B,G,R,A converter.
// ----------------------------------------------------------------------------
package pybs_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [2:0] MODE_RGB888   = 3'd0;
    localparam logic [2:0] MODE_BGR888   = 3'd1;
    localparam logic [2:0] MODE_BGRA8888 = 3'd2;
    localparam logic [2:0] MODE_VYUY     = 3'd3;
    localparam logic [2:0] MODE_YVYU     = 3'd4;
    localparam logic [2:0] MODE_UYVY     = 3'd5;
    localparam logic [2:0] MODE_YUYV     = 3'd6;
    localparam logic [2:0] MODE_RESET    = MODE_YUYV;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // one completed byte group with its (normalized) format
    typedef struct packed {
        logic [2:0]      mode;
        logic [3:0][7:0] bytes;
    } t_group;

    // luma position of the first pixel, yuv modes
    function automatic logic [1:0] y_pos(input logic [2:0] mode);
        logic [1:0] p;
        case (mode)
            MODE_VYUY: p = 2'd1;
            MODE_YVYU: p = 2'd0;
            MODE_UYVY: p = 2'd1;
            default:   p = 2'd0;
        endcase
        return p;
    endfunction

    // cb position, yuv modes; cr sits two bytes away
    function automatic logic [1:0] cb_pos(input logic [2:0] mode);
        logic [1:0] p;
        case (mode)
            MODE_VYUY: p = 2'd2;
            MODE_YVYU: p = 2'd3;
            MODE_UYVY: p = 2'd0;
            default:   p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] b_pos(input logic [2:0] mode);
        logic [1:0] p;
        case (mode)
            MODE_RGB888: p = 2'd0;
            MODE_BGR888: p = 2'd2;
            default:     p = 2'd3;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] g_pos(input logic [2:0] mode);
        logic [1:0] p;
        case (mode)
            MODE_BGRA8888: p = 2'd2;
            default:       p = 2'd1;
        endcase
        return p;
    endfunction

    function automatic logic [1:0] r_pos(input logic [2:0] mode);
        logic [1:0] p;
        case (mode)
            MODE_RGB888: p = 2'd2;
            MODE_BGR888: p = 2'd0;
            default:     p = 2'd1;
        endcase
        return p;
    endfunction

    // floor shift by 8 and clamp to 0..255
    function automatic logic [7:0] clip_shift(input logic signed [19:0] sum);
        logic [11:0] q;
        logic [7:0]  r;
        q = sum[19:8];
        if (q[11]) begin
            r = 8'd0;
        end else if (q[10:8] != 3'd0) begin
            r = 8'hff;
        end else begin
            r = q[7:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/pybs_front.sv @@
// ----------------------------------------------------------------------------
// pybs_front
// Format register, byte position tracking and group assembly; pushes each
// completed group toward the conversion side.
// ----------------------------------------------------------------------------
module pybs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [2:0]           i_cfg_data,
    input  logic                 i_valid,
    input  logic [7:0]           i_byte,
    input  logic                 i_start,
    output logic                 o_ready,
    output logic                 o_push,
    output pybs_pkg::t_group     o_group,
    input  logic                 i_push_ready
);

    logic [2:0]      r_mode;
    logic [1:0]      r_pos, n_pos;
    logic [7:0]      r_held [3];
    logic [1:0]      pos_eff;
    logic [2:0]      mode_eff;
    logic [1:0]      last_pos;
    logic            complete;
    logic            accept;
    pybs_pkg::t_group grp;

    assign o_ready  = i_push_ready;
    assign accept   = i_valid && i_push_ready;
    assign pos_eff  = i_start ? 2'd0 : r_pos;
    assign mode_eff = (r_mode == 3'd7) ? pybs_pkg::MODE_YUYV : r_mode;
    assign last_pos = (mode_eff <= pybs_pkg::MODE_BGRA8888) ? 2'd2 : 2'd3;
    assign complete = (pos_eff >= last_pos);

    always_comb begin
        grp.mode     = mode_eff;
        grp.bytes[0] = r_held[0];
        grp.bytes[1] = r_held[1];
        grp.bytes[2] = r_held[2];
        grp.bytes[3] = 8'd0;
        grp.bytes[pos_eff] = i_byte;
        n_pos = r_pos;
        if (accept) begin
            n_pos = complete ? 2'd0 : pos_eff + 2'd1;
        end
    end

    assign o_push  = accept && complete;
    assign o_group = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pybs_pkg::MODE_RESET;
            r_pos  <= 2'd0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !complete) begin
            r_held[pos_eff] <= i_byte;
        end
    end

endmodule

@@ rtl/pybs_queue.sv @@
// ----------------------------------------------------------------------------
// pybs_queue
// Small first-in first-out buffer of byte groups between front and back.
// ----------------------------------------------------------------------------
module pybs_queue #(
    parameter int unsigned Depth = pybs_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pybs_pkg::t_group i_group,
    output logic             o_push_ready,
    output logic             o_valid,
    output pybs_pkg::t_group o_group,
    input  logic             i_pop_ready
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    pybs_pkg::t_group r_mem [Depth];
    logic [PtrW-1:0]  r_wr, r_rd;
    logic [CntW-1:0]  r_cnt;
    logic             do_push, do_pop;

    assign o_push_ready = (r_cnt != CntW'(Depth));
    assign o_valid      = (r_cnt != '0);
    assign o_group      = r_mem[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

@@ rtl/pybs_back.sv @@
// ----------------------------------------------------------------------------
// pybs_back
// Pixel generation: byte reorder for rgb groups, two-stage bt.601 conversion
// for yuv groups (two pixels per group), output register.
// ----------------------------------------------------------------------------
module pybs_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  pybs_pkg::t_group i_group,
    output logic             o_pop_ready,
    output logic             o_valid,
    output logic [31:0]      o_data,
    output logic             o_last,
    input  logic             i_ready
);

    logic               is_rgb;
    logic               s1_load, s2_adv;
    logic               r_half;
    logic [1:0]         yp, cbp, crp;
    logic [7:0]         y_b, cb_b, cr_b;
    logic signed [17:0] c, d, e;

    logic               r_s1_valid;
    logic               r_s1_rgb, r_s1_last;
    logic [7:0]         r_s1_b, r_s1_g, r_s1_r;
    logic signed [17:0] r_py, r_pb, r_pgd, r_pge, r_pr;

    logic               r_out_valid;
    logic [31:0]        r_out_data;
    logic               r_out_last;
    logic signed [19:0] sum_b, sum_g, sum_r;
    logic [7:0]         pix_b, pix_g, pix_r;

    assign is_rgb      = (i_group.mode <= pybs_pkg::MODE_BGRA8888);
    assign s2_adv      = !r_out_valid || i_ready;
    assign s1_load     = !r_s1_valid || s2_adv;
    assign o_pop_ready = s1_load && (is_rgb || r_half);

    assign yp   = pybs_pkg::y_pos(i_group.mode) ^ {r_half, 1'b0};
    assign cbp  = pybs_pkg::cb_pos(i_group.mode);
    assign crp  = cbp ^ 2'd2;
    assign y_b  = i_group.bytes[yp];
    assign cb_b = i_group.bytes[cbp];
    assign cr_b = i_group.bytes[crp];
    assign c    = $signed({10'd0, y_b}) - 18'sd16;
    assign d    = $signed({10'd0, cb_b}) - 18'sd128;
    assign e    = $signed({10'd0, cr_b}) - 18'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_half      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= i_valid;
                if (i_valid && !is_rgb) begin
                    r_half <= !r_half;
                end
            end
            if (s2_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // product stage
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_rgb  <= is_rgb;
            r_s1_last <= is_rgb || r_half;
            r_s1_b    <= i_group.bytes[pybs_pkg::b_pos(i_group.mode)];
            r_s1_g    <= i_group.bytes[pybs_pkg::g_pos(i_group.mode)];
            r_s1_r    <= i_group.bytes[pybs_pkg::r_pos(i_group.mode)];
            r_py      <= c * 18'sd298;
            r_pb      <= d * 18'sd516;
            r_pgd     <= d * 18'sd100;
            r_pge     <= e * 18'sd208;
            r_pr      <= e * 18'sd409;
        end
    end

    // sum and clip stage
    assign sum_b = 20'(r_py) + 20'(r_pb) + 20'sd128;
    assign sum_g = 20'(r_py) - 20'(r_pgd) - 20'(r_pge) + 20'sd128;
    assign sum_r = 20'(r_py) + 20'(r_pr) + 20'sd128;
    assign pix_b = r_s1_rgb ? r_s1_b : pybs_pkg::clip_shift(sum_b);
    assign pix_g = r_s1_rgb ? r_s1_g : pybs_pkg::clip_shift(sum_g);
    assign pix_r = r_s1_rgb ? r_s1_r : pybs_pkg::clip_shift(sum_r);

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_out_data <= {pybs_pkg::ALPHA_OPAQUE, pix_r, pix_g, pix_b};
            r_out_last <= r_s1_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_last  = r_out_last;

endmodule

@@ rtl/packed_yuv_rgb_to_bgra_stream_unit.sv @@
// ----------------------------------------------------------------------------
// packed_yuv_rgb_to_bgra_stream_unit
// Packed 4:2:2 yuv / rgb byte stream to b,g,r,a pixel stream converter.
// ----------------------------------------------------------------------------
// Takes one source byte per cycle. A group of 3 bytes (rgb formats) or 4
// bytes (packed 4:2:2 formats) is assembled by the front end and queued;
// the back end turns a group into one pixel (rgb) or two pixels (yuv, bt.601
// limited range) at one pixel per cycle unless the output is held off, through
// a product stage, a sum and clip stage and the output register; the byte that
// completes a group is first registered in the group queue. Input stalls only
// when the queue (QueueDepth entries) is full, i.e. the output is held off.
// tuser on the input restarts grouping; tlast marks the last pixel of a group.
// Write the format register only while the stream is idle.
module packed_yuv_rgb_to_bgra_stream_unit #(
    parameter int unsigned QueueDepth = pybs_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_data,      // format_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // data_byte
    input  logic        s_axis_tuser,    // frame_start
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,    // blue, green, red, alpha
    output logic        m_axis_tlast     // last_of_group
);

    logic             push, push_ready, q_valid, pop_ready;
    pybs_pkg::t_group push_group, q_group;

    assign o_cfg_ready = 1'b1;

    pybs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (s_axis_tvalid),
        .i_byte       (s_axis_tdata),
        .i_start      (s_axis_tuser),
        .o_ready      (s_axis_tready),
        .o_push       (push),
        .o_group      (push_group),
        .i_push_ready (push_ready)
    );

    pybs_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_group      (push_group),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_group      (q_group),
        .i_pop_ready  (pop_ready)
    );

    pybs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_group     (q_group),
        .o_pop_ready (pop_ready),
        .o_valid     (m_axis_tvalid),
        .o_data      (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .i_ready     (m_axis_tready)
    );

endmodule

@@ dv/tb_packed_yuv_rgb_to_bgra_stream_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_packed_yuv_rgb_to_bgra_stream_unit
// Self-checking bench for the packed yuv / rgb to b,g,r,a stream converter.
// ----------------------------------------------------------------------------
// Source bytes go in on the input stream under every format code. A
// scoreboard rebuilds byte grouping and the bt.601 math for each accepted
// beat and queues the pixels it expects; every output beat is compared field
// by field in order. The run starts with a few hand-picked groups (clip
// limits, restarts, format switched with a group open, the spare format
// code), then random frames and broken fragments under three mixes of
// source and sink stalls.
// ----------------------------------------------------------------------------
module tb_packed_yuv_rgb_to_bgra_stream_unit;
    import pybs_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;
    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_LIMIT = 2000;
    localparam int SEG_BYTES = 67;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
        logic       last;
    } bgra_pixel_t;

    class bgra_scoreboard;
        logic [2:0]  format;
        int          position;
        logic [7:0]  held [3];
        bgra_pixel_t pixels_due [$];
        int          mismatches;
        int          bytes_seen;
        int          pixels_seen;

        function new();
            format = MODE_RESET;
            position = 0;
            foreach (held[i]) held[i] = 8'h00;
            mismatches = 0;
            bytes_seen = 0;
            pixels_seen = 0;
        endfunction

        function logic [7:0] saturate(int sum);
            int q;
            q = sum >>> 8;
            if (q < 0) return 8'h00;
            if (q > 255) return 8'hff;
            return q[7:0];
        endfunction

        function bgra_pixel_t yuv_pixel(logic [7:0] luma, logic [7:0] cb, logic [7:0] cr,
                                        logic last);
            bgra_pixel_t px;
            int c, d, e;
            c = int'(luma) - 16;
            d = int'(cb) - 128;
            e = int'(cr) - 128;
            px.blue = saturate(298 * c + 516 * d + 128);
            px.green = saturate(298 * c - 100 * d - 208 * e + 128);
            px.red = saturate(298 * c + 409 * e + 128);
            px.alpha = ALPHA_OPAQUE;
            px.last = last;
            return px;
        endfunction

        // one accepted source beat: update grouping, queue finished pixels
        function void note_source_byte(logic [7:0] data, logic start);
            int p, group_len, lu, cbi, cri, bi, gi, ri;
            logic [2:0] mode;
            logic [7:0] grp [4];
            bgra_pixel_t px;
            bytes_seen++;
            p = start ? 0 : position;
            mode = (format == MODE_UNUSED) ? MODE_YUYV : format;
            group_len = (mode <= MODE_BGRA8888) ? 3 : 4;
            if (p + 1 < group_len) begin
                held[p] = data;
                position = p + 1;
                return;
            end
            for (int i = 0; i < 3; i++) grp[i] = held[i];
            grp[3] = 8'h00;
            grp[p] = data;
            position = 0;
            if (mode <= MODE_BGRA8888) begin
                case (mode)
                    MODE_RGB888: begin
                        bi = 0; gi = 1; ri = 2;
                    end
                    MODE_BGR888: begin
                        bi = 2; gi = 1; ri = 0;
                    end
                    default: begin
                        bi = 3; gi = 2; ri = 1;
                    end
                endcase
                px.blue = grp[bi];
                px.green = grp[gi];
                px.red = grp[ri];
                px.alpha = ALPHA_OPAQUE;
                px.last = 1'b1;
                pixels_due.push_back(px);
            end else begin
                case (mode)
                    MODE_VYUY: begin
                        lu = 1; cbi = 2;
                    end
                    MODE_YVYU: begin
                        lu = 0; cbi = 3;
                    end
                    MODE_UYVY: begin
                        lu = 1; cbi = 0;
                    end
                    default: begin
                        lu = 0; cbi = 1;
                    end
                endcase
                cri = (cbi + 2) % 4;
                pixels_due.push_back(yuv_pixel(grp[lu], grp[cbi], grp[cri], 1'b0));
                pixels_due.push_back(yuv_pixel(grp[(lu + 2) % 4], grp[cbi], grp[cri], 1'b1));
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_pixel(logic [31:0] data, logic last);
            bgra_pixel_t want;
            pixels_seen++;
            if (pixels_due.size() == 0) begin
                report($sformatf("unexpected pixel %h last %b", data, last));
                return;
            end
            want = pixels_due.pop_front();
            if (data[7:0] !== want.blue)
                report($sformatf("blue %h, want %h", data[7:0], want.blue));
            if (data[15:8] !== want.green)
                report($sformatf("green %h, want %h", data[15:8], want.green));
            if (data[23:16] !== want.red)
                report($sformatf("red %h, want %h", data[23:16], want.red));
            if (data[31:24] !== want.alpha)
                report($sformatf("alpha %h, want %h", data[31:24], want.alpha));
            if (last !== want.last)
                report($sformatf("last %b, want %b", last, want.last));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_data = 3'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
    logic        s_axis_tuser = 1'b0;    // frame_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // blue, green, red, alpha
    logic        m_axis_tlast;           // last_of_group

    int src_idle_pct = 33;
    int sink_idle_pct = 50;
    int idle_cycles = 0;

    bgra_scoreboard sb = new();

    packed_yuv_rgb_to_bgra_stream_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // sink stalls
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                sb.format = i_cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                sb.note_source_byte(s_axis_tdata, s_axis_tuser);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_pixel(m_axis_tdata, m_axis_tlast);
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("stream stuck for %0d cycles", STALL_LIMIT);
        $display("tb_packed_yuv_rgb_to_bgra_stream_unit: errors");
        $finish;
    end

    function automatic logic [7:0] pick_byte();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hff : 8'h00;
        return 8'($urandom);
    endfunction

    // called and returns at a falling edge
    task automatic send_byte(input logic [7:0] data, input logic start);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= start;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // wait for every queued pixel, then let the pipeline run dry
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_format(input logic [2:0] mode);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int sent, n, group_len;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // yuyv out of reset: all-zero and all-ones groups hit both clip limits
        for (int i = 0; i < 4; i++) send_byte(8'h00, i == 0);
        for (int i = 0; i < 4; i++) send_byte(8'hff, i == 0);
        // frame start in the middle of a group
        send_byte(8'h10, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'heb, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'heb, 1'b0);
        send_byte(8'h80, 1'b0);
        // two bytes held when the group shrinks to three
        send_byte(8'h5a, 1'b1);
        send_byte(8'ha5, 1'b0);
        write_format(MODE_RGB888);
        send_byte(8'h3c, 1'b0);
        // spare code behaves as yuyv, then three bytes held into bgra
        write_format(MODE_UNUSED);
        for (int i = 0; i < 4; i++) send_byte(8'h40 + 8'(i * 37), i == 0);
        send_byte(8'h81, 1'b1);
        send_byte(8'h42, 1'b0);
        send_byte(8'h24, 1'b0);
        write_format(MODE_BGRA8888);
        send_byte(8'hc3, 1'b0);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 33; sink_idle_pct = 50;
                end
                1: begin
                    src_idle_pct = 50; sink_idle_pct = 33;
                end
                default: begin
                    src_idle_pct = 0; sink_idle_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 8; seg++) begin
                write_format(3'((seg * 3 + phase) % 8));
                group_len = (sb.format <= MODE_BGRA8888) ? 3 : 4;
                sent = 0;
                while (sent < SEG_BYTES) begin
                    if ($urandom_range(9) < 8) begin
                        // well-formed frame of whole groups
                        n = group_len * $urandom_range(1, 6);
                        for (int i = 0; i < n; i++) send_byte(pick_byte(), i == 0);
                    end else begin
                        // fragment with stray frame starts
                        n = $urandom_range(1, 5);
                        for (int i = 0; i < n; i++)
                            send_byte(pick_byte(), $urandom_range(3) == 0);
                    end
                    sent += n;
                end
            end
        end

        settle();
        $display("%0d source bytes in, %0d pixels checked, %0d mismatches",
                 sb.bytes_seen, sb.pixels_seen, sb.mismatches);
        $display("all eight format codes under three source/sink stall mixes");
        if (sb.mismatches == 0 && sb.pixels_due.size() == 0) begin
            $display("tb_packed_yuv_rgb_to_bgra_stream_unit: clean");
        end else begin
            $display("tb_packed_yuv_rgb_to_bgra_stream_unit: errors");
        end
        $finish;
    end

endmodule
